// ----- rtl/urxf_pkg.sv -----
// Shared types and codes for the receive FIFO with break flush.
package urxf_pkg;

  localparam int MODE_W  = 2;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 7;
  localparam int EVENT_W = 3;

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_RX     = 2'd0;
  localparam mode_t MODE_READ   = 2'd1;
  localparam mode_t MODE_CLEAR  = 2'd2;
  localparam mode_t MODE_UNUSED = 2'd3;

  typedef enum logic [EVENT_W-1:0] {
    EV_STORED  = 3'd0,
    EV_DROPPED = 3'd1,
    EV_BREAK   = 3'd2,
    EV_DATA    = 3'd3,
    EV_NONE    = 3'd4
  } event_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef logic cfg_idx_t;

  localparam cfg_idx_t REG_BREAK_EN   = 1'b0;
  localparam cfg_idx_t REG_BREAK_CHAR = 1'b1;

  localparam logic [BYTE_W-1:0] BREAK_CHAR_RST = 8'd17;

  typedef struct packed {
    logic              break_en;
    logic [BYTE_W-1:0] break_char;
  } cfg_t;

endpackage

// ----- rtl/urxf_in_if.sv -----
// Request channel carrying mode, received byte and read count.
interface urxf_in_if import urxf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [BYTE_W-1:0] rx_byte;
  logic [CNT_W-1:0]  read_count;

  modport source (output valid, output mode, output rx_byte, output read_count,
                  input ready);
  modport sink   (input valid, input mode, input rx_byte, input read_count,
                  output ready);
endinterface

// ----- rtl/urxf_out_if.sv -----
// Result channel carrying event code, data byte, last marker, fill level and break flag.
interface urxf_out_if import urxf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [EVENT_W-1:0] event_res;
  logic [BYTE_W-1:0]  data;
  logic               last;
  logic [CNT_W-1:0]   fill_level;
  logic               break_request;

  modport source (output valid, output event_res, output data, output last,
                  output fill_level, output break_request, input ready);
  modport sink   (input valid, input event_res, input data, input last,
                  input fill_level, input break_request, output ready);
endinterface

// ----- rtl/uart_rx_fifo_with_break_flush_unit.sv -----
// Top level of the receive FIFO with break flush: configuration registers and block wiring.
//
// Receive FIFO for a serial console, DEPTH bytes deep, held in a synchronous memory.
// A receive, clear or unused-mode request yields one registered result; such
// requests go through back to back while results are taken each cycle. A read
// request of n held bytes first fetches the oldest byte from the memory, then
// gives one byte per cycle from the memory read port while the output does not
// stall, with no new request taken until the last byte has been loaded into the
// result register. Configuration writes are registered and must only be made
// while the block is idle. The store needs no clearing after reset.
module uart_rx_fifo_with_break_flush_unit import urxf_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  urxf_in_if.sink           in_ch,
  urxf_out_if.source        out_ch,
  input  logic              cfg_we,
  input  cfg_idx_t          cfg_index,
  input  logic [BYTE_W-1:0] cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cfg_t              cfg_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.break_en   <= 1'b0;
      cfg_r.break_char <= BREAK_CHAR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BREAK_EN:   cfg_r.break_en   <= cfg_data[0];
        REG_BREAK_CHAR: cfg_r.break_char <= cfg_data;
        default: ;
      endcase
    end
  end

  urxf_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  urxf_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ----- rtl/urxf_mem.sv -----
// Byte store: one write port, one read port with registered read data.
module urxf_mem import urxf_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] store_r [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      store_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= store_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/urxf_ctrl.sv -----
// Sequencer: pointers, fill count, read burst and registered result slot.
module urxf_ctrl import urxf_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  urxf_in_if.sink           in_ch,
  urxf_out_if.source        out_ch,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [BYTE_W-1:0] mem_wdata,
  output logic              mem_re,
  output logic [AW-1:0]     mem_raddr,
  input  logic [BYTE_W-1:0] mem_rdata
);

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  state_t            state_r, state_nxt;
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     held_r, held_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;

  logic              out_v_r, out_v_nxt;
  event_t            out_ev_r, out_ev_nxt;
  logic [BYTE_W-1:0] out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;
  logic [CNT_W-1:0]  out_fill_r, out_fill_nxt;
  logic              out_brk_r, out_brk_nxt;

  logic              slot_free;
  logic              acc;
  logic [CNT_W-1:0]  held_ext;
  logic [CNT_W-1:0]  n_rd;
  logic              is_break;

  assign slot_free   = !out_v_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && slot_free;
  assign acc         = in_ch.valid && in_ch.ready;
  assign held_ext    = CNT_W'(held_r);
  assign n_rd        = (in_ch.read_count < held_ext) ? in_ch.read_count : held_ext;
  assign is_break    = cfg.break_en && (in_ch.rx_byte == cfg.break_char);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && in_ch.mode == MODE_READ && n_rd != '0) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (slot_free && rem_r == CW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    wr_ptr_nxt   = wr_ptr_r;
    rd_ptr_nxt   = rd_ptr_r;
    held_nxt     = held_r;
    rem_nxt      = rem_r;
    out_v_nxt    = out_v_r && !out_ch.ready;
    out_ev_nxt   = out_ev_r;
    out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;
    out_fill_nxt = out_fill_r;
    out_brk_nxt  = out_brk_r;
    mem_we       = 1'b0;
    mem_waddr    = wr_ptr_r;
    mem_wdata    = in_ch.rx_byte;
    mem_re       = 1'b0;
    mem_raddr    = rd_ptr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          out_data_nxt = '0;
          out_last_nxt = 1'b1;
          out_brk_nxt  = 1'b0;
          out_fill_nxt = held_ext;
          unique case (in_ch.mode)
            MODE_RX: begin
              out_v_nxt = 1'b1;
              if (is_break) begin
                wr_ptr_nxt   = '0;
                rd_ptr_nxt   = '0;
                held_nxt     = '0;
                out_ev_nxt   = EV_BREAK;
                out_fill_nxt = '0;
                out_brk_nxt  = 1'b1;
              end else if (held_r < CW'(DEPTH)) begin
                mem_we       = 1'b1;
                wr_ptr_nxt   = adv(wr_ptr_r);
                held_nxt     = held_r + CW'(1);
                out_ev_nxt   = EV_STORED;
                out_fill_nxt = CNT_W'(held_r + CW'(1));
              end else begin
                out_ev_nxt = EV_DROPPED;
              end
            end
            MODE_READ: begin
              if (n_rd == '0) begin
                out_v_nxt  = 1'b1;
                out_ev_nxt = EV_NONE;
              end else begin
                // fetch the oldest byte; results follow from the read state
                mem_re  = 1'b1;
                rem_nxt = CW'(n_rd);
              end
            end
            MODE_CLEAR: begin
              out_v_nxt    = 1'b1;
              wr_ptr_nxt   = '0;
              rd_ptr_nxt   = '0;
              held_nxt     = '0;
              out_ev_nxt   = EV_NONE;
              out_fill_nxt = '0;
            end
            default: begin
              out_v_nxt  = 1'b1;
              out_ev_nxt = EV_NONE;
            end
          endcase
        end
      end
      ST_READ: begin
        if (slot_free) begin
          out_v_nxt    = 1'b1;
          out_ev_nxt   = EV_DATA;
          out_data_nxt = mem_rdata;
          out_last_nxt = (rem_r == CW'(1));
          out_fill_nxt = CNT_W'(held_r - CW'(1));
          out_brk_nxt  = 1'b0;
          held_nxt     = held_r - CW'(1);
          rd_ptr_nxt   = adv(rd_ptr_r);
          rem_nxt      = rem_r - CW'(1);
          // prefetch the next byte while more remain
          if (rem_r != CW'(1)) begin
            mem_re    = 1'b1;
            mem_raddr = adv(rd_ptr_r);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      held_r   <= '0;
      rem_r    <= '0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      held_r   <= held_nxt;
      rem_r    <= rem_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ev_r   <= out_ev_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_fill_r <= out_fill_nxt;
    out_brk_r  <= out_brk_nxt;
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.event_res     = out_ev_r;
  assign out_ch.data          = out_data_r;
  assign out_ch.last          = out_last_r;
  assign out_ch.fill_level    = out_fill_r;
  assign out_ch.break_request = out_brk_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(DEPTH))
    else $error("fill count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    held_r == '0 |-> wr_ptr_r == rd_ptr_r)
    else $error("empty buffer with pointers apart");

  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> rem_r != '0 && rem_r <= held_r)
    else $error("read burst count out of range");

  a_read_start: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_ch.mode == MODE_READ && n_rd != '0 |=> state_r == ST_READ && !out_v_r)
    else $error("read request did not start a burst");

endmodule

// ----- dv/tb_uart_rx_fifo_with_break_flush_unit.sv -----
// Testbench for the receive FIFO with break flush: queued driver, scoreboard and checks.
module tb_uart_rx_fifo_with_break_flush_unit import urxf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = 64;
  localparam int AW             = $clog2(DEPTH);
  localparam int CLK_PERIOD     = 10;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [1:0] {
    ACT_REQUEST,
    ACT_IDLE,
    ACT_CONFIG,
    ACT_DRAIN
  } stim_kind_t;

  typedef struct {
    stim_kind_t       kind;
    mode_t            mode;
    logic [BYTE_W-1:0] rx_byte;
    logic [CNT_W-1:0] count;
    int unsigned      cycles;
    cfg_idx_t         index;
    logic [BYTE_W-1:0] value;
  } stim_t;

  typedef struct {
    event_t            ev;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [CNT_W-1:0]  fill;
    logic              brk;
  } fifo_event_t;

  logic clk = 1'b0;
  logic rst_n;
  logic              cfg_we;
  cfg_idx_t          cfg_index;
  logic [BYTE_W-1:0] cfg_data;

  urxf_in_if  in_ch ();
  urxf_out_if out_ch ();

  uart_rx_fifo_with_break_flush_unit #(.DEPTH(DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Stimulus plan, filled before reset.
  stim_t       stim_q[$];
  int unsigned request_total;
  logic        send_calm;
  logic [BYTE_W-1:0] plan_break_char;
  logic        plan_break_en;

  // Scoreboard state.
  fifo_event_t       events_due[$];
  int unsigned       mismatches;
  logic [BYTE_W-1:0] mdl_store [DEPTH];
  int unsigned       mdl_wr_ptr;
  int unsigned       mdl_rd_ptr;
  int unsigned       mdl_held;
  logic              mdl_break_en;
  logic [BYTE_W-1:0] mdl_break_char;

  int unsigned hold_left;
  logic        stim_done;
  int unsigned recv_stall;
  logic        recv_calm;
  int unsigned quiet_cycles;

  function automatic void queue_request(mode_t m, logic [BYTE_W-1:0] b,
                                        logic [CNT_W-1:0] c);
    stim_t s;
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s = '{kind: ACT_IDLE, mode: MODE_RX, rx_byte: '0, count: '0,
            cycles: gap - 1, index: REG_BREAK_EN, value: '0};
      stim_q.push_back(s);
    end
    s = '{kind: ACT_REQUEST, mode: m, rx_byte: b, count: c,
          cycles: 0, index: REG_BREAK_EN, value: '0};
    stim_q.push_back(s);
    request_total++;
  endfunction

  function automatic void queue_drain();
    stim_t s;
    s = '{kind: ACT_DRAIN, mode: MODE_RX, rx_byte: '0, count: '0,
          cycles: 0, index: REG_BREAK_EN, value: '0};
    stim_q.push_back(s);
  endfunction

  // Registers change only once the block has gone quiet.
  function automatic void queue_config(logic en, logic [BYTE_W-1:0] ch);
    stim_t s;
    queue_drain();
    s = '{kind: ACT_CONFIG, mode: MODE_RX, rx_byte: '0, count: '0,
          cycles: 0, index: REG_BREAK_EN, value: {7'd0, en}};
    stim_q.push_back(s);
    s.index = REG_BREAK_CHAR;
    s.value = ch;
    stim_q.push_back(s);
    plan_break_en   = en;
    plan_break_char = ch;
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    if ($urandom_range(0, 9) == 0) return plan_break_char;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom_range(0, 255));
    if (plan_break_en && b == plan_break_char) b = b ^ 8'h01;
    return b;
  endfunction

  function automatic logic [CNT_W-1:0] rand_count();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick <= 6) return CNT_W'($urandom_range(1, 8));
    if (pick == 7) return CNT_W'($urandom_range(9, 64));
    if (pick == 8) return 7'd64;
    return CNT_W'($urandom_range(65, 127));
  endfunction

  function automatic void random_phase(int unsigned n_items, logic long_fill);
    int unsigned goal;
    int unsigned pick;
    goal = request_total + n_items;
    if (long_fill) begin
      // Push past full so drops and pointer wrap both show up.
      repeat (DEPTH + 2)
        queue_request(MODE_RX, plain_byte(), CNT_W'($urandom_range(0, 127)));
      queue_request(MODE_READ, BYTE_W'($urandom_range(0, 255)), 7'd64);
    end
    while (request_total < goal) begin
      pick = $urandom_range(0, 19);
      if (pick < 11) begin
        repeat ($urandom_range(1, 10))
          queue_request(MODE_RX, rand_byte(), CNT_W'($urandom_range(0, 127)));
      end else if (pick < 17) begin
        queue_request(MODE_READ, BYTE_W'($urandom_range(0, 255)), rand_count());
      end else if (pick < 19) begin
        queue_request(MODE_CLEAR, BYTE_W'($urandom_range(0, 255)),
                      CNT_W'($urandom_range(0, 127)));
      end else begin
        queue_request(MODE_UNUSED, rand_byte(), CNT_W'($urandom_range(0, 127)));
      end
    end
  endfunction

  function automatic void push_event(event_t ev, logic [BYTE_W-1:0] d, logic lst,
                                     int unsigned fill, logic brk);
    fifo_event_t e;
    e.ev   = ev;
    e.data = d;
    e.last = lst;
    e.fill = fill[CNT_W-1:0];
    e.brk  = brk;
    events_due.push_back(e);
  endfunction

  function automatic void compute_fifo_events(mode_t m, logic [BYTE_W-1:0] b,
                                              logic [CNT_W-1:0] c);
    int unsigned n;
    case (m)
      MODE_RX: begin
        if (mdl_break_en && b == mdl_break_char) begin
          mdl_wr_ptr = 0;
          mdl_rd_ptr = 0;
          mdl_held   = 0;
          push_event(EV_BREAK, '0, 1'b1, 0, 1'b1);
        end else if (mdl_held < DEPTH) begin
          mdl_store[mdl_wr_ptr[AW-1:0]] = b;
          mdl_wr_ptr = (mdl_wr_ptr + 1 >= DEPTH) ? 0 : mdl_wr_ptr + 1;
          mdl_held++;
          push_event(EV_STORED, '0, 1'b1, mdl_held, 1'b0);
        end else begin
          push_event(EV_DROPPED, '0, 1'b1, mdl_held, 1'b0);
        end
      end
      MODE_READ: begin
        n = (c < mdl_held) ? c : mdl_held;
        if (n == 0) push_event(EV_NONE, '0, 1'b1, mdl_held, 1'b0);
        for (int unsigned k = 0; k < n; k++) begin
          mdl_held--;
          push_event(EV_DATA, mdl_store[mdl_rd_ptr[AW-1:0]], k + 1 == n, mdl_held, 1'b0);
          mdl_rd_ptr = (mdl_rd_ptr + 1 >= DEPTH) ? 0 : mdl_rd_ptr + 1;
        end
      end
      MODE_CLEAR: begin
        mdl_wr_ptr = 0;
        mdl_rd_ptr = 0;
        mdl_held   = 0;
        push_event(EV_NONE, '0, 1'b1, 0, 1'b0);
      end
      default: push_event(EV_NONE, '0, 1'b1, mdl_held, 1'b0);
    endcase
  endfunction

  function automatic void check_field(string name, logic [BYTE_W-1:0] exp_v,
                                      logic [BYTE_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Request driver.
  always @(posedge clk) begin
    logic  valid_nx;
    logic  we_nx;
    stim_t head;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      cfg_we      <= 1'b0;
      hold_left   <= 0;
      stim_done   <= 1'b0;
    end else begin
      valid_nx = in_ch.valid && !in_ch.ready;
      we_nx    = 1'b0;
      if (!valid_nx) begin
        if (hold_left != 0) begin
          hold_left <= hold_left - 1;
        end else if (stim_q.size() != 0) begin
          head = stim_q[0];
          case (head.kind)
            ACT_REQUEST: begin
              in_ch.mode       <= head.mode;
              in_ch.rx_byte    <= head.rx_byte;
              in_ch.read_count <= head.count;
              valid_nx = 1'b1;
              void'(stim_q.pop_front());
            end
            ACT_IDLE: begin
              hold_left <= head.cycles;
              void'(stim_q.pop_front());
            end
            ACT_CONFIG: begin
              cfg_index <= head.index;
              cfg_data  <= head.value;
              we_nx = 1'b1;
              void'(stim_q.pop_front());
            end
            default: begin
              // Hold until every outstanding result is back, then let the block settle.
              if (!in_ch.valid && events_due.size() == 0) begin
                hold_left <= SETTLE_CYCLES;
                void'(stim_q.pop_front());
              end
            end
          endcase
        end else if (!in_ch.valid) begin
          stim_done <= 1'b1;
        end
      end
      in_ch.valid <= valid_nx;
      cfg_we      <= we_nx;
    end
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    int unsigned s;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall   <= 0;
      recv_calm    <= 1'b0;
    end else if (out_ch.valid && out_ch.ready) begin
      if ($urandom_range(0, 39) == 0) recv_calm <= !recv_calm;
      s = recv_calm ? 0 : $urandom_range(0, 5);
      recv_stall   <= s;
      out_ch.ready <= (s == 0);
    end else if (recv_stall != 0) begin
      recv_stall   <= recv_stall - 1;
      out_ch.ready <= (recv_stall == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Scoreboard: track config writes, predict on accepted requests, check results.
  always @(posedge clk) begin
    fifo_event_t want;
    if (!rst_n) begin
      mdl_wr_ptr     = 0;
      mdl_rd_ptr     = 0;
      mdl_held       = 0;
      mdl_break_en   = 1'b0;
      mdl_break_char = BREAK_CHAR_RST;
      events_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BREAK_EN:   mdl_break_en   = cfg_data[0];
          REG_BREAK_CHAR: mdl_break_char = cfg_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        compute_fifo_events(in_ch.mode, in_ch.rx_byte, in_ch.read_count);
      if (out_ch.valid && out_ch.ready) begin
        if (events_due.size() == 0) begin
          $error("unexpected result: event_res %0d data %0d fill_level %0d",
                 out_ch.event_res, out_ch.data, out_ch.fill_level);
          mismatches++;
        end else begin
          want = events_due.pop_front();
          check_field("event_res", BYTE_W'(want.ev), BYTE_W'(out_ch.event_res));
          check_field("data", want.data, out_ch.data);
          check_field("last", BYTE_W'(want.last), BYTE_W'(out_ch.last));
          check_field("fill_level", BYTE_W'(want.fill), BYTE_W'(out_ch.fill_level));
          check_field("break_request", BYTE_W'(want.brk),
                      BYTE_W'(out_ch.break_request));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("tb_uart_rx_fifo_with_break_flush_unit: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_RX;
    in_ch.rx_byte    = '0;
    in_ch.read_count = '0;
    out_ch.ready     = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_BREAK_EN;
    cfg_data         = '0;
    mismatches       = 0;
    request_total    = 0;
    send_calm        = 1'b0;
    plan_break_en    = 1'b0;
    plan_break_char  = BREAK_CHAR_RST;

    // Break disabled: the break character is stored like any other byte.
    queue_request(MODE_READ, 8'h00, 7'd5);
    queue_request(MODE_RX, BREAK_CHAR_RST, 7'd0);
    queue_request(MODE_RX, 8'h00, 7'd127);
    queue_request(MODE_RX, 8'hFF, 7'd64);
    queue_request(MODE_RX, 8'hA5, 7'd1);
    queue_request(MODE_READ, 8'hFF, 7'd0);
    queue_request(MODE_READ, 8'h00, 7'd2);
    queue_request(MODE_READ, 8'h55, 7'd64);
    queue_request(MODE_UNUSED, 8'hFF, 7'd127);
    queue_request(MODE_RX, 8'h5A, 7'd0);
    queue_request(MODE_CLEAR, 8'hFF, 7'd127);
    queue_request(MODE_READ, 8'h00, 7'd127);

    // Break enabled on zero: flush with data held and on an empty buffer.
    queue_config(1'b1, 8'h00);
    queue_request(MODE_RX, 8'h33, 7'd0);
    queue_request(MODE_RX, 8'h44, 7'd0);
    queue_request(MODE_RX, 8'h00, 7'd0);
    queue_request(MODE_RX, 8'h00, 7'd127);
    queue_request(MODE_READ, 8'h00, 7'd1);
    queue_request(MODE_RX, 8'h80, 7'd0);
    queue_request(MODE_UNUSED, 8'h00, 7'd0);

    random_phase(60, 1'b1);
    queue_config(1'b1, 8'hFF);
    random_phase(55, 1'b0);
    queue_config(1'b0, BYTE_W'($urandom_range(0, 255)));
    random_phase(55, 1'b0);
    queue_config(1'b1, BYTE_W'($urandom_range(0, 255)));
    random_phase(55, 1'b1);
    queue_drain();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    wait (stim_done);
    @(posedge clk);
    if (events_due.size() != 0) begin
      $error("%0d expected results never arrived", events_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb_uart_rx_fifo_with_break_flush_unit: PASS");
    end else begin
      $display("tb_uart_rx_fifo_with_break_flush_unit: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/urxf_pkg.sv
rtl/urxf_in_if.sv
rtl/urxf_out_if.sv
rtl/urxf_mem.sv
rtl/urxf_ctrl.sv
rtl/uart_rx_fifo_with_break_flush_unit.sv
dv/tb_uart_rx_fifo_with_break_flush_unit.sv
